[hdl/ncs_pkg.sv]
package ncs_pkg;

   localparam int MAX_CENTERS = 16;
   localparam int MAX_DIM     = 64;
   localparam int VALUE_BITS  = 16;

   localparam int CIDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int SQ_W   = 2 * VALUE_BITS;
   localparam int SUM_W  = 48;
   localparam int ACC_W  = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

   localparam int COUNT_W     = 5;
   localparam int IDX_OUT_W   = 4;
   localparam int CIN_W       = 4;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);
   localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // one accepted word as seen by every cell
   typedef struct packed {
      logic                  load;
      logic                  query;
      logic [CIN_W-1:0]      cidx;
      logic [ADDR_W-1:0]     addr;
      logic [VALUE_BITS-1:0] value;
   } op_type;

   // running best of the minimum search, passed cell to cell
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [CIDX_W-1:0] idx;
      logic [SUM_W-1:0]  distance;
   } tok_type;

endpackage

[hdl/ncs_cell.sv]
module ncs_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ncs_pkg::CIDX_W-1:0] cell_id,
   input  logic                       active,
   input  ncs_pkg::op_type            op,
   input  ncs_pkg::tok_type           tok_in,
   output ncs_pkg::tok_type           tok_out
);
   import ncs_pkg::*;

   logic [VALUE_BITS-1:0] mem [MAX_DIM];
   logic [VALUE_BITS-1:0] rd_ff;
   logic [VALUE_BITS-1:0] q_ff;
   logic                  a_vld_ff;
   logic [SQ_W-1:0]       sq_ff;
   logic                  b_vld_ff;
   logic [SUM_W-1:0]      sum_ff;
   tok_type               tok_ff;

   logic signed [VALUE_BITS:0] diff;
   logic [VALUE_BITS-1:0]      mag;
   logic [ACC_W-1:0]           acc;
   logic [SUM_W-1:0]           sum_in;
   logic                       take;
   tok_type                    tok_in_w;

   // center table of this cell: write on a matching load, registered read
   always_ff @(posedge clock) begin
      if (op.load && (32'(op.cidx) == 32'(cell_id))) begin
         mem[op.addr] <= op.value;
      end
      if (op.query) begin
         rd_ff <= mem[op.addr];
      end
      q_ff  <= op.value;
      sq_ff <= SQ_W'(mag) * SQ_W'(mag);
   end

   always_comb begin
      diff = $signed({rd_ff[VALUE_BITS-1], rd_ff}) - $signed({q_ff[VALUE_BITS-1], q_ff});
      mag  = diff[VALUE_BITS] ? VALUE_BITS'(-diff) : VALUE_BITS'(diff);
      acc  = ACC_W'(sum_ff) + ACC_W'(sq_ff);
      sum_in = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc);
      take = active && (!tok_in.found || (sum_ff < tok_in.distance));
      tok_in_w = tok_in;
      if (take) begin
         tok_in_w.found    = 1'b1;
         tok_in_w.idx      = cell_id;
         tok_in_w.distance = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         sum_ff   <= '0;
         tok_ff   <= '0;
      end else begin
         a_vld_ff <= op.query && active;
         b_vld_ff <= a_vld_ff;
         tok_ff   <= tok_in_w;
         // drop the sum once the search has passed this cell
         if (tok_in.valid) begin
            sum_ff <= '0;
         end else if (b_vld_ff) begin
            sum_ff <= sum_in;
         end
      end
   end

   assign tok_out = tok_ff;

endmodule

[hdl/nearest_center_search.sv]
// Load words and non-final query words are taken one per cycle while no search is in flight.
// A final query word stalls the request side until its result moves into the response
// register: the final word drains to every accumulator, the search token passes the
// cells one after another, and a result that finds that register busy is parked.
// Synchronous active-high reset clears all distance sums, sets center_count
// to 16 and empties the response register; the center table is not cleared.
module nearest_center_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [3:0]  req_center_index,
   input  logic [5:0]  req_dim_index,
   input  logic signed [15:0] req_feature_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_nearest_index,
   output logic [47:0] rsp_nearest_distance,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data
);
   import ncs_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DRAIN,
      ST_SEARCH,
      ST_PARK
   } state_type;

   state_type              state_ff;
   logic                   drain_ff;
   logic                   start_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   rsp_valid_ff;
   logic [IDX_OUT_W-1:0]   rsp_idx_ff;
   logic [SUM_W-1:0]       rsp_dist_ff;
   logic [IDX_OUT_W-1:0]   park_idx_ff;
   logic [SUM_W-1:0]       park_dist_ff;

   logic                   accept;
   logic                   dim_ok;
   logic                   last_query;
   logic                   slot_free;
   logic                   rsp_load;
   logic [MAX_CENTERS-1:0] active;
   op_type                 op;
   tok_type                tok [MAX_CENTERS+1];

   // Take words only while no search is in flight.
   assign req_stall = (state_ff != ST_RUN);
   assign accept    = req_valid && !req_stall;
   assign dim_ok    = (32'(req_dim_index) < MAX_DIM);
   assign last_query = accept && (req_action == ACT_QUERY) && req_last_element;
   // The response register can take a new result this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   // A finished search or a parked result moves into the response register.
   assign rsp_load  = slot_free && (((state_ff == ST_SEARCH) && tok[MAX_CENTERS].valid)
                                    || (state_ff == ST_PARK));

   always_comb begin
      op.load  = accept && (req_action == ACT_LOAD) && dim_ok
                 && (32'(req_center_index) < MAX_CENTERS);
      op.query = accept && (req_action == ACT_QUERY) && dim_ok;
      op.cidx  = req_center_index;
      op.addr  = ADDR_W'(req_dim_index);
      op.value = VALUE_BITS'(req_feature_value);
   end

   // Centers in use: a count of zero still keeps center 0; anything above
   // the row length covers every cell.
   genvar c;
   generate
      for (c = 0; c < MAX_CENTERS; c++) begin : g_cell
         assign active[c] = (c == 0) || (32'(c) < 32'(count_ff));
         ncs_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .cell_id (CIDX_W'(c)),
            .active  (active[c]),
            .op      (op),
            .tok_in  (tok[c]),
            .tok_out (tok[c+1])
         );
      end
   endgenerate

   // Search token enters cell 0 with nothing found yet.
   always_comb begin
      tok[0].valid    = start_ff;
      tok[0].found    = 1'b0;
      tok[0].idx      = '0;
      tok[0].distance = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         drain_ff     <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // launch the search token once the drain is done
         start_ff <= (state_ff == ST_DRAIN) && drain_ff;
         // raise valid on a new result, release the word once it is taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_RUN: begin
               if (last_query) begin
                  state_ff <= ST_DRAIN;
                  drain_ff <= 1'b0;
               end
            end
            ST_DRAIN: begin
               // wait for the final word to reach every accumulator
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (tok[MAX_CENTERS].valid) begin
                  if (slot_free) begin
                     rsp_idx_ff   <= IDX_OUT_W'(tok[MAX_CENTERS].idx);
                     rsp_dist_ff  <= tok[MAX_CENTERS].distance;
                     state_ff     <= ST_RUN;
                  end else begin
                     park_idx_ff  <= IDX_OUT_W'(tok[MAX_CENTERS].idx);
                     park_dist_ff <= tok[MAX_CENTERS].distance;
                     state_ff     <= ST_PARK;
                  end
               end
            end
            ST_PARK: begin
               // hold the result until the response register frees up
               if (slot_free) begin
                  rsp_idx_ff   <= park_idx_ff;
                  rsp_dist_ff  <= park_dist_ff;
                  state_ff     <= ST_RUN;
               end
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_nearest_index    = rsp_idx_ff;
   assign rsp_nearest_distance = rsp_dist_ff;

endmodule

[sim/ncs_result_checker.sv]
`timescale 1ns / 100ps

module ncs_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [3:0]  req_center_index,
   input  logic [5:0]  req_dim_index,
   input  logic [15:0] req_feature_value,
   input  logic        req_last_element,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_nearest_index,
   input  logic [47:0] rsp_nearest_distance,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned load_words,
   output int unsigned query_words,
   output int unsigned result_words
);
   import ncs_pkg::*;

   typedef struct packed {
      logic [3:0]       idx;
      logic [SUM_W-1:0] distance;
   } nearest_type;

   logic signed [VALUE_BITS-1:0] center_tbl [MAX_CENTERS][MAX_DIM];
   logic [SUM_W-1:0]             dist_sum [MAX_CENTERS];
   logic [4:0]                   center_count;
   nearest_type                  expected_nearest [$];

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // a count of zero searches center 0 alone; anything past the table clamps
   function automatic int unsigned centers_in_use();
      if (center_count == '0) return 1;
      if (center_count > MAX_CENTERS) return MAX_CENTERS;
      return center_count;
   endfunction

   task automatic take_word(input logic act, input logic [3:0] cidx, input logic [5:0] dim,
                            input logic signed [VALUE_BITS-1:0] value, input logic is_last);
      int               diff;
      longint           total;
      int unsigned      live;
      int unsigned      best;
      logic [SUM_W-1:0] best_dist;
      nearest_type      found;
      if (act == ACT_LOAD) begin
         load_words++;
         if (cidx < MAX_CENTERS && dim < MAX_DIM) center_tbl[cidx][dim] = value;
      end else begin
         query_words++;
         live = centers_in_use();
         if (dim < MAX_DIM) begin
            for (int c = 0; c < live; c++) begin
               diff        = int'(center_tbl[c][dim]) - int'(value);
               total       = longint'(dist_sum[c]) + longint'(diff) * longint'(diff);
               dist_sum[c] = (total > longint'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
            end
         end
         if (is_last) begin
            best      = 0;
            best_dist = dist_sum[0];
            // strict compare: ties keep the lower index
            for (int c = 1; c < live; c++) begin
               if (dist_sum[c] < best_dist) begin
                  best      = c;
                  best_dist = dist_sum[c];
               end
            end
            found.idx      = 4'(best);
            found.distance = best_dist;
            expected_nearest.push_back(found);
            for (int c = 0; c < MAX_CENTERS; c++) dist_sum[c] = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      nearest_type want;
      if (reset) begin
         center_count = COUNT_RESET;
         for (int c = 0; c < MAX_CENTERS; c++) dist_sum[c] = '0;
         expected_nearest.delete();
         fail_count   = 0;
         load_words   = 0;
         query_words  = 0;
         result_words = 0;
      end else begin
         // compare before predicting: a word taken at this edge cannot answer itself
         if (rsp_valid && !rsp_stall) begin
            if (expected_nearest.size() == 0) begin
               report_mismatch($sformatf("unexpected result index %0d distance %0d",
                                         rsp_nearest_index, rsp_nearest_distance));
            end else begin
               want = expected_nearest.pop_front();
               result_words++;
               if (rsp_nearest_index !== want.idx)
                  report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                            rsp_nearest_index, want.idx));
               if (rsp_nearest_distance !== want.distance)
                  report_mismatch($sformatf("nearest_distance %0d, expected %0d",
                                            rsp_nearest_distance, want.distance));
            end
         end
         if (csr_write_enable) center_count = csr_write_data;
         if (req_valid && !req_stall)
            take_word(req_action, req_center_index, req_dim_index, req_feature_value,
                      req_last_element);
      end
      pending <= expected_nearest.size();
   end

endmodule

[sim/tb_nearest_center_search.sv]
`timescale 1ns / 100ps

module tb_nearest_center_search;
   import ncs_pkg::*;

   // run guard, long receiver hold-off, and words sent in each random phase
   localparam int unsigned LIMIT_CYCLES = 1_000_000;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned PHASE_WORDS  = 66;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_action;
   logic [3:0]        req_center_index;
   logic [5:0]        req_dim_index;
   logic signed [15:0] req_feature_value;
   logic              req_last_element;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [3:0]        rsp_nearest_index;
   logic [47:0]       rsp_nearest_distance;
   logic              csr_write_enable;
   logic [4:0]        csr_write_data;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned load_words;
   int unsigned query_words;
   int unsigned result_words;

   // stimulus bookkeeping: which table entries hold a value, how many
   // centers the search covers, and the dimensions most queries draw from
   bit          loaded [MAX_CENTERS][MAX_DIM];
   int unsigned live_centers = MAX_CENTERS;
   logic [5:0]  dim_pool [6];
   int unsigned phase_counts [9] = '{16, 0, 31, 1, 17, 2, 9, 0, 16};
   int unsigned sent_words;
   int unsigned cycle_count;
   bit          calm;
   bit          hold_request;

   nearest_center_search u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_center_index     (req_center_index),
      .req_dim_index        (req_dim_index),
      .req_feature_value    (req_feature_value),
      .req_last_element     (req_last_element),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_nearest_index    (rsp_nearest_index),
      .rsp_nearest_distance (rsp_nearest_distance),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   ncs_result_checker u_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_center_index     (req_center_index),
      .req_dim_index        (req_dim_index),
      .req_feature_value    (req_feature_value),
      .req_last_element     (req_last_element),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_nearest_index    (rsp_nearest_index),
      .rsp_nearest_distance (rsp_nearest_distance),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .fail_count           (fail_count),
      .pending              (pending),
      .load_words           (load_words),
      .query_words          (query_words),
      .result_words         (result_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap length shared by both sides: mostly none, often short, rarely long.
   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Feature values: extremes, a narrow band around zero that breeds ties,
   // and the full range.
   function automatic logic [15:0] pick_feature();
      int unsigned r;
      logic [15:0] v;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            default: v = 16'hFFFF;
         endcase
      end else if (r < 40) begin
         v = 16'(int'($urandom_range(0, 6)) - 3);
      end else begin
         v = 16'($urandom);
      end
      return v;
   endfunction

   function automatic logic [5:0] pick_dim();
      if ($urandom_range(0, 3) != 0) return dim_pool[$urandom_range(0, 5)];
      return 6'($urandom_range(0, MAX_DIM - 1));
   endfunction

   // Offer one word and hold it until taken, then maybe idle the sender.
   task automatic push_word(input logic act, input logic [3:0] cidx, input logic [5:0] dim,
                            input logic [15:0] value, input logic is_last);
      int unsigned gap;
      req_valid         <= 1'b1;
      req_action        <= act;
      req_center_index  <= cidx;
      req_dim_index     <= dim;
      req_feature_value <= value;
      req_last_element  <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_words++;
      if (act == ACT_LOAD) loaded[cidx][dim] = 1'b1;
      if (!calm) begin
         gap = pause_len();
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Loads ignore the last flag, so toggle it freely.
   task automatic load_center(input logic [3:0] cidx, input logic [5:0] dim,
                              input logic [15:0] value);
      push_word(ACT_LOAD, cidx, dim, value, 1'($urandom_range(0, 1)));
   endtask

   // Fill any center in use that has no value at this dimension before
   // querying it, so the search never reads an unwritten entry.
   task automatic query_element(input logic [5:0] dim, input logic [15:0] value,
                                input logic is_last);
      for (int c = 0; c < live_centers; c++) begin
         if (!loaded[c][dim]) load_center(4'(c), dim, pick_feature());
      end
      push_word(ACT_QUERY, 4'($urandom_range(0, 15)), dim, value, is_last);
   endtask

   // One query point of random length, with stray loads mixed in as noise.
   task automatic query_point();
      int unsigned len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 15)
            load_center(4'($urandom_range(0, 15)), 6'($urandom_range(0, MAX_DIM - 1)),
                        pick_feature());
         query_element(pick_dim(), pick_feature(), i == len - 1);
      end
   endtask

   // Drop valid, wait for every result, then let the search pipe run dry.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (MAX_CENTERS + 8) @(posedge clock);
   endtask

   task automatic write_count(input logic [4:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      live_centers = (value == 0) ? 1 : (value > MAX_CENTERS) ? MAX_CENTERS : value;
   endtask

   // Receiver: alternate open and stalled stretches; honor one long hold-off
   // on request while the sender keeps pushing words into the block.
   initial begin
      int unsigned span;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_stall    <= 1'b1;
            span = LONG_HOLD;
         end else if (calm || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 8);
         end else begin
            rsp_stall <= 1'b1;
            span = pause_len() + 1;
         end
         repeat (span) @(posedge clock);
      end
   end

   // Guard against a hung block.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL nearest_center_search");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= ACT_LOAD;
      req_center_index <= '0;
      req_dim_index    <= '0;
      req_feature_value <= '0;
      req_last_element <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      calm             = 1'b0;
      hold_request     = 1'b0;
      sent_words       = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      dim_pool = '{6'd0, 6'd63, 6'd21, 6'd42, 6'($urandom), 6'($urandom)};
      phase_counts[7] = $urandom_range(0, 31);

      // Directed: two centers at opposite extremes, widest difference,
      // exact match, a tie, a two-element point, and loads marked last.
      write_count(5'd2);
      push_word(ACT_LOAD, 4'd0, 6'd0, 16'h7FFF, 1'b0);
      push_word(ACT_LOAD, 4'd1, 6'd0, 16'h8000, 1'b1);
      query_element(6'd0, 16'h8000, 1'b1);
      query_element(6'd0, 16'h7FFF, 1'b1);
      load_center(4'd0, 6'd1, 16'd5);
      load_center(4'd1, 6'd1, 16'hFFFB);
      query_element(6'd1, 16'h0000, 1'b1);
      query_element(6'd0, 16'h0000, 1'b0);
      query_element(6'd1, 16'h0000, 1'b1);
      load_center(4'd15, 6'd63, 16'h5555);
      load_center(4'd15, 6'd63, 16'hAAAA);
      load_center(4'd1, 6'd63, 16'h0000);
      load_center(4'd0, 6'd63, 16'hFFFF);
      push_word(ACT_QUERY, 4'd15, 6'd63, 16'hFFFF, 1'b1);
      push_word(ACT_QUERY, 4'd0, 6'd63, 16'h0001, 1'b0);
      push_word(ACT_QUERY, 4'd15, 6'd42 & 6'd0, 16'h7FFF, 1'b1);

      // Random phases over a spread of center counts, extremes included.
      // Phase 1 runs without idling; phase 2 starts the long hold-off.
      foreach (phase_counts[p]) begin
         int unsigned start;
         write_count(5'(phase_counts[p]));
         calm = (p == 1);
         if (p == 2) hold_request <= 1'b1;
         start = sent_words;
         while (sent_words - start < PHASE_WORDS) query_point();
         calm = 1'b0;
      end

      settle();
      $display("Covered %0d center loads and %0d query words, counts 0 through 31,",
               load_words, query_words);
      $display("with ties, extreme features and a long receiver hold-off; %0d results checked.",
               result_words);
      if (fail_count == 0) begin
         $display("PASS nearest_center_search");
      end else begin
         $display("FAIL nearest_center_search");
      end
      $finish;
   end

endmodule

[files.f]
hdl/ncs_pkg.sv
hdl/ncs_cell.sv
hdl/nearest_center_search.sv
sim/ncs_result_checker.sv
sim/tb_nearest_center_search.sv
